// File: hdl/tstf_pkg.sv
// ----------------------------------------------------------------------------
// tstf_pkg
// Shared types and constants of the two-stage top-k threshold filter.
// ----------------------------------------------------------------------------
package tstf_pkg;

  localparam int BATCH_SIZE = 4;
  localparam int WORD_W     = 32;
  localparam int FILL_W     = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
  localparam int CNT_W      = $clog2(BATCH_SIZE + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [BATCH_SIZE-1:0] batch_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic valid;   // cell holds a live entry
    logic insert;  // broadcast value is sorted in this cycle
  } cell_ctrl_t;

  // batch descriptor handed to the output buffer
  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] count;
    logic             second;
    logic             done;
  } batch_ctrl_t;

endpackage

// File: hdl/tstf_cell.sv
// ----------------------------------------------------------------------------
// tstf_cell
// One slot of the insertion chain: keep, take the new value, or take the
// left neighbor's entry.
// ----------------------------------------------------------------------------
module tstf_cell (
  input  logic                clk_i,
  input  tstf_pkg::word_t     value_i,
  input  tstf_pkg::cell_ctrl_t ctrl_i,
  input  logic                left_le_i,
  input  tstf_pkg::word_t     left_val_i,
  output logic                le_o,
  output tstf_pkg::word_t     val_o,
  output tstf_pkg::word_t     ins_o
);
  import tstf_pkg::*;

  word_t entry_q;
  word_t entry_d;

  // equal values stay ahead of the new one
  assign le_o  = ctrl_i.valid && (entry_q <= value_i);
  assign ins_o = le_o ? entry_q : (left_le_i ? value_i : left_val_i);
  assign val_o = entry_q;

  assign entry_d = ctrl_i.insert ? ins_o : entry_q;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// File: hdl/tstf_out_buf.sv
// ----------------------------------------------------------------------------
// tstf_out_buf
// Batch buffer: load a whole batch, shift it out one beat at a time.
// ----------------------------------------------------------------------------
module tstf_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tstf_pkg::batch_ctrl_t ctrl_i,
  input  tstf_pkg::batch_t      data_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tstf_pkg::word_t       out_value_o,
  output logic                  last_of_batch_o,
  output logic                  second_phase_o,
  output logic                  stream_done_o
);
  import tstf_pkg::*;

  batch_t           buf_q, buf_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             second_q, second_d;
  logic             done_q, done_d;
  logic             pop;

  assign pop    = (cnt_q != '0) && out_ready_i;
  assign free_o = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_ready_i);

  always_comb begin
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    second_d = second_q;
    done_d   = done_q;
    if (ctrl_i.load) begin
      buf_d    = data_i;
      cnt_d    = ctrl_i.count;
      second_d = ctrl_i.second;
      done_d   = ctrl_i.done;
    end else if (pop) begin
      // advance the batch by one slot
      for (int i = 0; i < BATCH_SIZE - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q    <= buf_d;
    second_q <= second_d;
    done_q   <= done_d;
  end

  assign out_valid_o     = (cnt_q != '0);
  assign out_value_o     = buf_q[0];
  assign last_of_batch_o = (cnt_q == CNT_W'(1));
  assign second_phase_o  = second_q;
  assign stream_done_o   = done_q;

endmodule

// File: hdl/two_stage_topk_threshold_filter.sv
// ----------------------------------------------------------------------------
// two_stage_topk_threshold_filter
// Two-phase batch sorter with a frozen threshold for the second phase.
// ----------------------------------------------------------------------------
// The block takes one 32-bit value per beat and sorts it into a chain of
// BATCH_SIZE cells: every cell compares the broadcast value with its entry
// and either keeps it, takes the new value, or takes its left neighbor's
// entry. A full chain is copied into a batch buffer that sends the entries in
// ascending order, one beat per cycle while out_ready is high, last_of_batch
// on the final one. In phase one every batch updates the threshold and the
// forwarded count; an end marker, or a value that finds the count at or above
// the limit, freezes the threshold, drops the partial batch and that value,
// and starts phase two. In phase two only values below the threshold are
// sorted in. The next end marker flushes the remaining entries with
// stream_done set (nothing if the chain is empty) and the block halts; later
// beats are accepted and dropped. A beat that completes a batch is held off
// only until the batch buffer is sending its last entry, so input and output
// both run at one value per cycle. The user must write the configuration
// (forward_limit at 0x0, end_marker at 0x4) over the APB port only while the
// block is idle, which the block does not enforce; pready is always high.
// ----------------------------------------------------------------------------
module two_stage_topk_threshold_filter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input stream
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tstf_pkg::word_t       value_i,
  // output stream
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tstf_pkg::word_t       out_value_o,
  output logic                  last_of_batch_o,
  output logic                  second_phase_o,
  output logic                  stream_done_o
);
  import tstf_pkg::*;

  localparam logic [1:0] PH_ONE  = 2'd0;
  localparam logic [1:0] PH_TWO  = 2'd1;
  localparam logic [1:0] PH_HALT = 2'd2;

  localparam logic REG_LIMIT  = 1'b0;
  localparam logic REG_MARKER = 1'b1;

  // configuration registers
  word_t limit_q, marker_q;
  logic  cfg_wr;

  // control and threshold state
  logic [1:0]        phase_q, phase_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  word_t             fwd_cnt_q, fwd_cnt_d;
  word_t             batch_thr_q, batch_thr_d;
  word_t             final_thr_q, final_thr_d;

  // chain signals; index 0 is the smallest entry
  cell_ctrl_t        cell_ctrl [BATCH_SIZE];
  logic [BATCH_SIZE:0] le_chain;
  word_t             left_val [BATCH_SIZE];
  batch_t            ins_vals, cur_vals;

  // beat decode
  logic        is_marker, fill_last, do_insert, emit_full, emit_flush, emit_now;
  logic        accept, ob_free;
  logic [WORD_W:0] fwd_sum;
  batch_ctrl_t batch_ctrl;

  // --------------------------------------------------------------------------
  // APB configuration
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= WORD_W'(1024);
      marker_q <= '1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LIMIT:  limit_q  <= pwdata;
        REG_MARKER: marker_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LIMIT:  prdata = limit_q;
      REG_MARKER: prdata = marker_q;
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Beat decode
  // --------------------------------------------------------------------------
  assign is_marker = (value_i == marker_q);
  assign fill_last = (fill_q == FILL_W'(BATCH_SIZE - 1));

  always_comb begin
    do_insert  = 1'b0;
    emit_full  = 1'b0;
    emit_flush = 1'b0;
    case (phase_q)
      PH_ONE: begin
        if (!(is_marker || (fwd_cnt_q >= limit_q))) begin
          do_insert = 1'b1;
          emit_full = fill_last;
        end
      end
      PH_TWO: begin
        if (is_marker) begin
          emit_flush = (fill_q != '0);
        end else if (value_i < final_thr_q) begin
          do_insert = 1'b1;
          emit_full = fill_last;
        end
      end
      default: ;
    endcase
  end

  assign emit_now   = emit_full || emit_flush;
  // hold the beat only if it makes a batch the buffer cannot take yet
  assign in_ready_o = !emit_now || ob_free;
  assign accept     = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Insertion chain
  // --------------------------------------------------------------------------
  assign le_chain[0] = 1'b1;

  for (genvar i = 0; i < BATCH_SIZE; i++) begin : g_cell
    assign cell_ctrl[i].valid  = (fill_q > FILL_W'(i));
    assign cell_ctrl[i].insert = accept && do_insert;
    if (i == 0) begin : g_head
      assign left_val[i] = value_i;
    end else begin : g_body
      assign left_val[i] = cur_vals[i-1];
    end

    tstf_cell u_cell (
      .clk_i      (clk_i),
      .value_i    (value_i),
      .ctrl_i     (cell_ctrl[i]),
      .left_le_i  (le_chain[i]),
      .left_val_i (left_val[i]),
      .le_o       (le_chain[i+1]),
      .val_o      (cur_vals[i]),
      .ins_o      (ins_vals[i])
    );
  end

  // --------------------------------------------------------------------------
  // Phase sequencer
  // --------------------------------------------------------------------------
  assign fwd_sum = {1'b0, fwd_cnt_q} + (WORD_W + 1)'(BATCH_SIZE);

  always_comb begin
    phase_d     = phase_q;
    fill_d      = fill_q;
    fwd_cnt_d   = fwd_cnt_q;
    batch_thr_d = batch_thr_q;
    final_thr_d = final_thr_q;
    if (accept) begin
      case (phase_q)
        PH_ONE: begin
          if (!do_insert) begin
            // freeze the threshold, drop the partial batch
            final_thr_d = batch_thr_q;
            phase_d     = PH_TWO;
            fill_d      = '0;
          end else if (emit_full) begin
            batch_thr_d = ins_vals[BATCH_SIZE-1];
            fwd_cnt_d   = fwd_sum[WORD_W] ? '1 : fwd_sum[WORD_W-1:0];
            fill_d      = '0;
          end else begin
            fill_d = fill_q + FILL_W'(1);
          end
        end
        PH_TWO: begin
          if (is_marker) begin
            phase_d = PH_HALT;
            fill_d  = '0;
          end else if (do_insert) begin
            fill_d = emit_full ? '0 : fill_q + FILL_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ONE;
      fill_q      <= '0;
      fwd_cnt_q   <= '0;
      batch_thr_q <= '1;
      final_thr_q <= '1;
    end else begin
      phase_q     <= phase_d;
      fill_q      <= fill_d;
      fwd_cnt_q   <= fwd_cnt_d;
      batch_thr_q <= batch_thr_d;
      final_thr_q <= final_thr_d;
    end
  end

  // --------------------------------------------------------------------------
  // Batch buffer
  // --------------------------------------------------------------------------
  assign batch_ctrl.load   = accept && emit_now;
  assign batch_ctrl.count  = emit_flush ? CNT_W'(fill_q) : CNT_W'(BATCH_SIZE);
  assign batch_ctrl.second = (phase_q == PH_TWO);
  assign batch_ctrl.done   = emit_flush;

  tstf_out_buf u_out_buf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (batch_ctrl),
    .data_i          (emit_flush ? cur_vals : ins_vals),
    .free_o          (ob_free),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_value_o     (out_value_o),
    .last_of_batch_o (last_of_batch_o),
    .second_phase_o  (second_phase_o),
    .stream_done_o   (stream_done_o)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    batch_ctrl.load |-> ob_free)
    else $error("batch loaded while buffer busy");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HALT) |=> (phase_q == PH_HALT))
    else $error("left halted phase");

  a_no_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_ONE) |=> (phase_q != PH_ONE))
    else $error("returned to phase one");

  a_halt_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HALT) |-> ((fill_q == '0) && !batch_ctrl.load))
    else $error("activity after halt");

  a_fwd_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_ONE) |=> $stable(fwd_cnt_q) && $stable(final_thr_q))
    else $error("phase-one state changed in phase two");

endmodule
